/* rtl/wsie_pkg.sv */
// Package of the security information element parser: record kinds, status
// codes, suite constants, the queue entry and output record types.
// No dependencies; the RTL modules use it by scoped names and the verification files import it.
`default_nettype none

package wsie_pkg;

   typedef enum logic [2:0] {
      KIND_GROUP    = 3'd0,
      KIND_PAIRWISE = 3'd1,
      KIND_AKM      = 3'd2,
      KIND_CAPS     = 3'd3,
      KIND_END      = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_SHORT       = 2'd1,
      ST_BAD_VERSION = 2'd2,
      ST_BAD_HEADER  = 2'd3
   } status_type;

   localparam logic [1:0]  CLASS_IEEE   = 2'd0;
   localparam logic [1:0]  CLASS_VENDOR = 2'd1;
   localparam logic [1:0]  CLASS_OTHER  = 2'd2;

   localparam logic [23:0] OUI_IEEE     = 24'h000FAC;
   localparam logic [23:0] OUI_VENDOR   = 24'h0050F2;
   localparam logic [7:0]  WPA_OUI_TYPE = 8'h01;
   localparam logic [15:0] VERSION_ONE  = 16'd1;
   localparam logic [7:0]  CIPHER_TKIP  = 8'd2;
   localparam logic [7:0]  CIPHER_CCMP  = 8'd4;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic       a_valid;
      kind_type   a_kind;
      logic [1:0] a_idx;
      logic [23:0] a_oui;
      logic [7:0] a_type;
      logic [15:0] a_caps;
      logic       d_valid;
      kind_type   d_kind;
      logic       d_fmt;
      logic       e_valid;
      status_type e_status;
      logic [2:0] e_pw;
      logic [2:0] e_akm;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      kind_type    record_kind;
      logic [1:0]  suite_index;
      logic [23:0] suite_oui;
      logic [7:0]  suite_type;
      logic [1:0]  oui_class;
      logic        suite_known;
      logic        from_default;
      logic [15:0] capabilities_value;
      status_type  status;
      logic [2:0]  pairwise_total;
      logic [2:0]  akm_total;
      logic        last_record;
   } rec_type;

   function automatic logic [7:0] wpa_hdr_byte(input logic [1:0] pos);
      logic [7:0] b;
      case (pos)
         2'd0:    b = OUI_VENDOR[23:16];
         2'd1:    b = OUI_VENDOR[15:8];
         2'd2:    b = OUI_VENDOR[7:0];
         default: b = WPA_OUI_TYPE;
      endcase
      return b;
   endfunction

   function automatic logic [1:0] oui_class_of(input logic [23:0] oui);
      logic [1:0] c;
      if (oui == OUI_IEEE) begin
         c = CLASS_IEEE;
      end else if (oui == OUI_VENDOR) begin
         c = CLASS_VENDOR;
      end else begin
         c = CLASS_OTHER;
      end
      return c;
   endfunction

   function automatic logic suite_named(input kind_type kind, input logic [1:0] cls,
                                        input logic [7:0] stype);
      logic k;
      k = 1'b0;
      if (kind == KIND_AKM) begin
         if (cls == CLASS_IEEE) begin
            k = (stype >= 8'd1) && (stype <= 8'd18);
         end else if (cls == CLASS_VENDOR) begin
            k = (stype >= 8'd1) && (stype <= 8'd2);
         end
      end else begin
         if (cls == CLASS_IEEE) begin
            k = (stype <= 8'd13);
         end else if (cls == CLASS_VENDOR) begin
            k = (stype <= 8'd5);
         end
      end
      return k;
   endfunction

endpackage

`default_nettype wire

/* rtl/wsie_if.sv */
// Channel interfaces of the parser: body byte requests and result records.
// Depends on nothing; the top level and the front and back modules use them.
`default_nettype none

interface wsie_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       byte_present;
   logic       end_of_body;

   modport source (output valid, output byte_value, output byte_present,
                   output end_of_body, input ready);
   modport sink (input valid, input byte_value, input byte_present,
                 input end_of_body, output ready);
endinterface

interface wsie_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  record_kind;
   logic [1:0]  suite_index;
   logic [23:0] suite_oui;
   logic [7:0]  suite_type;
   logic [1:0]  oui_class;
   logic        suite_known;
   logic        from_default;
   logic [15:0] capabilities_value;
   logic [1:0]  status;
   logic [2:0]  pairwise_total;
   logic [2:0]  akm_total;
   logic        last_record;

   modport source (output valid, output record_kind, output suite_index,
                   output suite_oui, output suite_type, output oui_class,
                   output suite_known, output from_default,
                   output capabilities_value, output status,
                   output pairwise_total, output akm_total,
                   output last_record, input ready);
   modport sink (input valid, input record_kind, input suite_index,
                 input suite_oui, input suite_type, input oui_class,
                 input suite_known, input from_default,
                 input capabilities_value, input status,
                 input pairwise_total, input akm_total,
                 input last_record, output ready);
endinterface

`default_nettype wire

/* rtl/wlan_security_ie_parser_top.sv */
// A record reaches rsp_chan through the queue and then the output register: the edge
// that accepts its transaction writes the queue, and the output register loads it when free.
// Throughput: one request transaction per cycle while the four-entry queue has room;
// one record per cycle leaves the output register while the receiver is ready, so a
// transaction with several records holds the emitter while the queue keeps taking requests.
// Reset is synchronous and active high; it clears the parse state and the format.
`default_nettype none

module wlan_security_ie_parser_top #(
   parameter int MAX_SUITES = 4
) (
   input  wire logic  clock,
   input  wire logic  reset,
   wsie_req_if.sink   req_chan,
   wsie_rsp_if.source rsp_chan,
   input  wire logic  csr_we,
   input  wire logic  csr_wdata
);

   wsie_pkg::queue_status_type q_status;
   wsie_pkg::entry_type        push_entry, head_entry;
   logic                       push, pop;

   wsie_front #(
      .MAX_SUITES(MAX_SUITES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req_chan (req_chan),
      .q_status (q_status),
      .q_push   (push),
      .q_entry  (push_entry)
   );

   wsie_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head_entry(head_entry),
      .status    (q_status)
   );

   wsie_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_entry(head_entry),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

/* rtl/wsie_front.sv */
// Front end of the parser: accepts body bytes, runs the parse phase machine
// and pushes one queue entry per transaction that causes records.
// Depends on wsie_pkg and wsie_req_if.
`default_nettype none

module wsie_front #(
   parameter int MAX_SUITES = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic                      csr_wdata,
   wsie_req_if.sink                       req_chan,
   input  wire wsie_pkg::queue_status_type q_status,
   output logic                           q_push,
   output wsie_pkg::entry_type            q_entry
);

   localparam int CW = $clog2(MAX_SUITES + 1);

   typedef enum logic [3:0] {
      PH_START, PH_HDR, PH_VER, PH_GROUP, PH_PWCNT, PH_PWSUITE, PH_PWSKIP,
      PH_AKMCNT, PH_AKMSUITE, PH_AKMSKIP, PH_CAPS, PH_DONE, PH_FAIL
   } phase_type;

   phase_type            phase_ff, phase_in, cur_phase;
   logic [1:0]           pos_ff, pos_in;
   logic [23:0]          buf_ff, buf_in;
   logic [15:0]          count_ff, count_in;
   logic [CW-1:0]        taken_ff, taken_in, taken_next;
   logic [17:0]          skip_ff, skip_in;
   logic [CW-1:0]        pw_seen_ff, pw_seen_in;
   logic [CW-1:0]        akm_seen_ff, akm_seen_in;
   wsie_pkg::status_type err_ff, err_in, end_status;
   logic                 fmt_ff, fmt_in;
   logic                 accept;
   logic [15:0]          word;
   wsie_pkg::entry_type  ent;

   function automatic logic [CW-1:0] sat(input logic [15:0] w);
      return (w > 16'(MAX_SUITES)) ? CW'(MAX_SUITES) : CW'(w);
   endfunction

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign word           = {req_chan.byte_value, buf_ff[7:0]};
   assign taken_next     = taken_ff + CW'(1);

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      buf_in      = buf_ff;
      count_in    = count_ff;
      taken_in    = taken_ff;
      skip_in     = skip_ff;
      pw_seen_in  = pw_seen_ff;
      akm_seen_in = akm_seen_ff;
      err_in      = err_ff;
      fmt_in      = csr_we ? csr_wdata : fmt_ff;
      cur_phase   = phase_ff;
      end_status  = err_ff;
      ent         = '0;
      ent.d_fmt   = fmt_ff;

      if (accept && req_chan.byte_present) begin
         if (phase_ff == PH_START) begin
            cur_phase = fmt_ff ? PH_HDR : PH_VER;
         end
         phase_in = cur_phase;
         case (cur_phase)
            PH_HDR: begin
               if (req_chan.byte_value != wsie_pkg::wpa_hdr_byte(pos_ff)) begin
                  err_in = wsie_pkg::ST_BAD_HEADER;
               end
               if (pos_ff == 2'd3) begin
                  phase_in = PH_VER;
                  pos_in   = 2'd0;
               end else begin
                  pos_in = pos_ff + 2'd1;
               end
            end
            PH_VER, PH_PWCNT, PH_AKMCNT, PH_CAPS: begin
               if (pos_ff == 2'd0) begin
                  buf_in = {16'd0, req_chan.byte_value};
                  pos_in = 2'd1;
               end else begin
                  pos_in = 2'd0;
                  case (cur_phase)
                     PH_VER: begin
                        if (err_ff == wsie_pkg::ST_BAD_HEADER) begin
                           phase_in = PH_FAIL;
                        end else if (word != wsie_pkg::VERSION_ONE) begin
                           err_in   = wsie_pkg::ST_BAD_VERSION;
                           phase_in = PH_FAIL;
                        end else begin
                           phase_in = PH_GROUP;
                        end
                     end
                     PH_PWCNT: begin
                        count_in   = word;
                        pw_seen_in = sat(word);
                        taken_in   = '0;
                        phase_in   = (word == 16'd0) ? PH_AKMCNT : PH_PWSUITE;
                     end
                     PH_AKMCNT: begin
                        count_in    = word;
                        akm_seen_in = sat(word);
                        taken_in    = '0;
                        if (word != 16'd0) begin
                           phase_in = PH_AKMSUITE;
                        end else begin
                           phase_in = fmt_ff ? PH_DONE : PH_CAPS;
                        end
                     end
                     default: begin
                        ent.a_valid = 1'b1;
                        ent.a_kind  = wsie_pkg::KIND_CAPS;
                        ent.a_caps  = word;
                        phase_in    = PH_DONE;
                     end
                  endcase
               end
            end
            PH_GROUP, PH_PWSUITE, PH_AKMSUITE: begin
               if (pos_ff != 2'd3) begin
                  buf_in = {buf_ff[15:0], req_chan.byte_value};
                  pos_in = pos_ff + 2'd1;
               end else begin
                  pos_in      = 2'd0;
                  ent.a_valid = 1'b1;
                  ent.a_oui   = buf_ff;
                  ent.a_type  = req_chan.byte_value;
                  if (cur_phase == PH_GROUP) begin
                     ent.a_kind = wsie_pkg::KIND_GROUP;
                     phase_in   = PH_PWCNT;
                  end else begin
                     ent.a_kind = (cur_phase == PH_PWSUITE) ? wsie_pkg::KIND_PAIRWISE
                                                            : wsie_pkg::KIND_AKM;
                     ent.a_idx  = 2'(taken_ff);
                     taken_in   = taken_next;
                     if (taken_next >= sat(count_ff)) begin
                        if (cur_phase == PH_PWSUITE) begin
                           if (count_ff > 16'(MAX_SUITES)) begin
                              skip_in  = {count_ff - 16'(MAX_SUITES), 2'b00};
                              phase_in = PH_PWSKIP;
                           end else begin
                              phase_in = PH_AKMCNT;
                           end
                        end else begin
                           if ((count_ff > 16'(MAX_SUITES)) && !fmt_ff) begin
                              skip_in  = {count_ff - 16'(MAX_SUITES), 2'b00};
                              phase_in = PH_AKMSKIP;
                           end else begin
                              phase_in = fmt_ff ? PH_DONE : PH_CAPS;
                           end
                        end
                     end
                  end
               end
            end
            PH_PWSKIP, PH_AKMSKIP: begin
               if (skip_ff != 18'd0) begin
                  skip_in = skip_ff - 18'd1;
               end
               if (skip_in == 18'd0) begin
                  pos_in = 2'd0;
                  if (cur_phase == PH_PWSKIP) begin
                     phase_in = PH_AKMCNT;
                  end else begin
                     phase_in = fmt_ff ? PH_DONE : PH_CAPS;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (accept && req_chan.end_of_body) begin
         end_status = err_in;
         case (phase_in)
            PH_START, PH_HDR, PH_VER, PH_PWSUITE, PH_AKMSUITE: begin
               end_status = wsie_pkg::ST_SHORT;
            end
            PH_GROUP: begin
               ent.d_valid = 1'b1;
               ent.d_kind  = wsie_pkg::KIND_GROUP;
               end_status  = wsie_pkg::ST_OK;
            end
            PH_PWCNT: begin
               ent.d_valid = 1'b1;
               ent.d_kind  = wsie_pkg::KIND_PAIRWISE;
               pw_seen_in  = CW'(1);
               end_status  = wsie_pkg::ST_OK;
            end
            default: begin
            end
         endcase
         ent.e_valid  = 1'b1;
         ent.e_status = end_status;
         ent.e_pw     = 3'(pw_seen_in);
         ent.e_akm    = 3'(akm_seen_in);
         phase_in     = PH_START;
         pos_in       = 2'd0;
         buf_in       = '0;
         count_in     = '0;
         taken_in     = '0;
         skip_in      = '0;
         pw_seen_in   = '0;
         akm_seen_in  = '0;
         err_in       = wsie_pkg::ST_OK;
      end
   end

   assign q_push  = accept && (ent.a_valid || ent.d_valid || ent.e_valid);
   assign q_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         pos_ff      <= '0;
         buf_ff      <= '0;
         count_ff    <= '0;
         taken_ff    <= '0;
         skip_ff     <= '0;
         pw_seen_ff  <= '0;
         akm_seen_ff <= '0;
         err_ff      <= wsie_pkg::ST_OK;
         fmt_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         buf_ff      <= buf_in;
         count_ff    <= count_in;
         taken_ff    <= taken_in;
         skip_ff     <= skip_in;
         pw_seen_ff  <= pw_seen_in;
         akm_seen_ff <= akm_seen_in;
         err_ff      <= err_in;
         fmt_ff      <= fmt_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/wsie_queue.sv */
// Short queue between the parser front end and the record emitter.
// Depends on wsie_pkg for the entry type and the queue depth.
`default_nettype none

module wsie_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire wsie_pkg::entry_type   push_entry,
   input  wire logic                  pop,
   output wsie_pkg::entry_type        head_entry,
   output wsie_pkg::queue_status_type status
);

   localparam int DEPTH = wsie_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   wsie_pkg::entry_type mem [DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]       count_ff, count_in;

   assign status.full  = (count_ff == NW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_entry   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push)
      else $error("Queue written while full.");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("Queue read while empty.");
`endif

endmodule

`default_nettype wire

/* rtl/wsie_back.sv */
// Back end of the parser: turns queue entries into result records, one per
// cycle while the receiver is ready, classifying each suite, into a registered output stage.
// Depends on wsie_pkg and wsie_rsp_if.
`default_nettype none

module wsie_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire wsie_pkg::entry_type        head_entry,
   input  wire wsie_pkg::queue_status_type q_status,
   output logic                           pop,
   wsie_rsp_if.source                     rsp_chan
);

   logic [2:0]        present, pending, pick, done_ff, done_in;
   logic              load, valid_ff, valid_in;
   wsie_pkg::rec_type rec_ff, rec_in;
   logic [23:0]       d_oui;
   logic [7:0]        d_type;
   logic [1:0]        cls;

   assign present = {head_entry.e_valid, head_entry.d_valid, head_entry.a_valid};
   assign pending = q_status.empty ? 3'b000 : (present & ~done_ff);
   assign load    = (!valid_ff || rsp_chan.ready) && (pending != 3'b000);
   assign pop     = load && ((pending & ~pick) == 3'b000);
   assign d_oui   = head_entry.d_fmt ? wsie_pkg::OUI_VENDOR : wsie_pkg::OUI_IEEE;
   assign d_type  = head_entry.d_fmt ? wsie_pkg::CIPHER_TKIP : wsie_pkg::CIPHER_CCMP;

   always_comb begin
      pick   = 3'b000;
      cls    = wsie_pkg::CLASS_IEEE;
      rec_in = '0;
      if (pending[0]) begin
         pick = 3'b001;
         rec_in.record_kind = head_entry.a_kind;
         if (head_entry.a_kind == wsie_pkg::KIND_CAPS) begin
            rec_in.capabilities_value = head_entry.a_caps;
         end else begin
            cls                = wsie_pkg::oui_class_of(head_entry.a_oui);
            rec_in.suite_index = head_entry.a_idx;
            rec_in.suite_oui   = head_entry.a_oui;
            rec_in.suite_type  = head_entry.a_type;
            rec_in.oui_class   = cls;
            rec_in.suite_known = wsie_pkg::suite_named(head_entry.a_kind, cls,
                                                       head_entry.a_type);
         end
      end else if (pending[1]) begin
         pick                = 3'b010;
         cls                 = wsie_pkg::oui_class_of(d_oui);
         rec_in.record_kind  = head_entry.d_kind;
         rec_in.suite_oui    = d_oui;
         rec_in.suite_type   = d_type;
         rec_in.oui_class    = cls;
         rec_in.suite_known  = wsie_pkg::suite_named(head_entry.d_kind, cls, d_type);
         rec_in.from_default = 1'b1;
      end else begin
         pick                  = 3'b100;
         rec_in.record_kind    = wsie_pkg::KIND_END;
         rec_in.status         = head_entry.e_status;
         rec_in.pairwise_total = head_entry.e_pw;
         rec_in.akm_total      = head_entry.e_akm;
         rec_in.last_record    = 1'b1;
      end
   end

   always_comb begin
      done_in  = done_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         done_in  = pop ? 3'b000 : (done_ff | pick);
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= 3'b000;
      end else begin
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff <= rec_in;
      end
   end

   assign rsp_chan.valid              = valid_ff;
   assign rsp_chan.record_kind        = rec_ff.record_kind;
   assign rsp_chan.suite_index        = rec_ff.suite_index;
   assign rsp_chan.suite_oui          = rec_ff.suite_oui;
   assign rsp_chan.suite_type         = rec_ff.suite_type;
   assign rsp_chan.oui_class          = rec_ff.oui_class;
   assign rsp_chan.suite_known        = rec_ff.suite_known;
   assign rsp_chan.from_default       = rec_ff.from_default;
   assign rsp_chan.capabilities_value = rec_ff.capabilities_value;
   assign rsp_chan.status             = rec_ff.status;
   assign rsp_chan.pairwise_total     = rec_ff.pairwise_total;
   assign rsp_chan.akm_total          = rec_ff.akm_total;
   assign rsp_chan.last_record        = rec_ff.last_record;

`ifndef SYNTHESIS
   a_done_clear_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_status.empty |-> (done_ff == 3'b000))
      else $error("Emitter progress left over with no queued entry.");

   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rec_ff.last_record) |-> (rec_ff.record_kind == wsie_pkg::KIND_END))
      else $error("Closing flag on a record that is not an end status.");
`endif

endmodule

`default_nettype wire

/* verif/wsie_record_checker.sv */
// Record checker for the security information element parser: watches both channels,
// predicts the records of every accepted transaction and compares them in order.
// Depends on wsie_pkg and the channel interfaces in wsie_if.sv.
`timescale 1ns / 1ps

module wsie_record_checker
   import wsie_pkg::*;
(
   input  logic clock,
   input  logic reset,
   wsie_req_if  req,
   wsie_rsp_if  rsp,
   input  logic csr_we,
   input  logic csr_wdata,
   output int   fail_count,
   output int   pending_records
);

   localparam int SUITE_LIMIT = 4;

   typedef enum logic [3:0] {
      P_START, P_HDR, P_VER, P_GROUP, P_PWCNT, P_PWSUITE, P_PWSKIP,
      P_AKMCNT, P_AKMSUITE, P_AKMSKIP, P_CAPS, P_DONE, P_FAIL
   } parse_phase_type;

   logic            wpa_format;
   parse_phase_type phase;
   logic [1:0]      field_pos;
   logic [23:0]     byte_buf;
   logic [15:0]     announced;
   logic [2:0]      taken;
   logic [17:0]     skip_left;
   logic [2:0]      pw_seen;
   logic [2:0]      akm_seen;
   status_type      fault;
   rec_type         expected_records[$];

   function automatic logic [2:0] capped(input logic [15:0] n);
      return (n > SUITE_LIMIT) ? 3'(SUITE_LIMIT) : n[2:0];
   endfunction

   function automatic string describe(input rec_type r);
      return $sformatf({"kind=%0d idx=%0d oui=%06h type=%02h class=%0d known=%0b ",
                        "dflt=%0b caps=%04h st=%0d pw=%0d akm=%0d last=%0b"},
                       r.record_kind, r.suite_index, r.suite_oui, r.suite_type,
                       r.oui_class, r.suite_known, r.from_default,
                       r.capabilities_value, r.status, r.pairwise_total,
                       r.akm_total, r.last_record);
   endfunction

   task automatic note_failure(input string what, input rec_type want, input rec_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t %s", $time, what);
         $display("   expected %s", describe(want));
         $display("   actual   %s", describe(got));
      end
   endtask

   task automatic enter(input parse_phase_type ph);
      phase = ph;
      field_pos = 2'd0;
   endtask

   task automatic clear_parse();
      enter(P_START);
      byte_buf = '0;
      announced = '0;
      taken = '0;
      skip_left = '0;
      pw_seen = '0;
      akm_seen = '0;
      fault = ST_OK;
   endtask

   task automatic emit_suite(input kind_type kind, input logic [1:0] idx,
                             input logic [23:0] oui, input logic [7:0] stype,
                             input logic dflt);
      rec_type    r;
      logic [1:0] cls;
      r = '0;
      cls = (oui == OUI_IEEE) ? CLASS_IEEE : (oui == OUI_VENDOR) ? CLASS_VENDOR : CLASS_OTHER;
      r.record_kind = kind;
      r.suite_index = idx;
      r.suite_oui = oui;
      r.suite_type = stype;
      r.oui_class = cls;
      if (kind == KIND_AKM) begin
         r.suite_known = (cls == CLASS_IEEE) ? (stype >= 8'd1 && stype <= 8'd18) :
                         (cls == CLASS_VENDOR) ? (stype >= 8'd1 && stype <= 8'd2) : 1'b0;
      end else begin
         r.suite_known = (cls == CLASS_IEEE) ? (stype <= 8'd13) :
                         (cls == CLASS_VENDOR) ? (stype <= 8'd5) : 1'b0;
      end
      r.from_default = dflt;
      expected_records.push_back(r);
   endtask

   task automatic emit_other(input kind_type kind, input logic [15:0] caps,
                             input status_type st, input logic [2:0] pw,
                             input logic [2:0] akm, input logic last);
      rec_type r;
      r = '0;
      r.record_kind = kind;
      r.capabilities_value = caps;
      r.status = st;
      r.pairwise_total = pw;
      r.akm_total = akm;
      r.last_record = last;
      expected_records.push_back(r);
   endtask

   task automatic after_akm_list();
      enter(wpa_format ? P_DONE : P_CAPS);
   endtask

   task automatic open_list(input bit pairwise);
      taken = '0;
      if (announced != 0) begin
         enter(pairwise ? P_PWSUITE : P_AKMSUITE);
      end else if (pairwise) begin
         enter(P_AKMCNT);
      end else begin
         after_akm_list();
      end
   endtask

   // WPA skips surplus pairwise suites but drops everything after a long AKM list.
   task automatic close_list(input bit pairwise);
      if (announced > SUITE_LIMIT && (pairwise || !wpa_format)) begin
         skip_left = 18'(announced - 16'(SUITE_LIMIT)) << 2;
         enter(pairwise ? P_PWSKIP : P_AKMSKIP);
      end else if (pairwise) begin
         enter(P_AKMCNT);
      end else begin
         after_akm_list();
      end
   endtask

   task automatic parse_body_byte(input logic [7:0] b);
      logic [1:0]  pos;
      logic [15:0] word;
      logic [31:0] hdr;
      kind_type    kind;
      pos = field_pos;
      hdr = {OUI_VENDOR, WPA_OUI_TYPE};
      if (phase == P_START) begin
         enter(wpa_format ? P_HDR : P_VER);
      end
      case (phase)
         P_HDR: begin
            if (b != hdr[8 * (3 - pos) +: 8]) begin
               fault = ST_BAD_HEADER;
            end
            if (pos == 2'd3) begin
               enter(P_VER);
            end else begin
               field_pos = pos + 2'd1;
            end
         end
         P_VER, P_PWCNT, P_AKMCNT, P_CAPS: begin
            if (pos == 2'd0) begin
               byte_buf = {16'd0, b};
               field_pos = 2'd1;
            end else begin
               word = {b, byte_buf[7:0]};
               case (phase)
                  P_VER: begin
                     if (fault == ST_BAD_HEADER) begin
                        enter(P_FAIL);
                     end else if (word != VERSION_ONE) begin
                        fault = ST_BAD_VERSION;
                        enter(P_FAIL);
                     end else begin
                        enter(P_GROUP);
                     end
                  end
                  P_PWCNT: begin
                     announced = word;
                     pw_seen = capped(word);
                     open_list(1'b1);
                  end
                  P_AKMCNT: begin
                     announced = word;
                     akm_seen = capped(word);
                     open_list(1'b0);
                  end
                  default: begin
                     emit_other(KIND_CAPS, word, ST_OK, 3'd0, 3'd0, 1'b0);
                     enter(P_DONE);
                  end
               endcase
            end
         end
         P_GROUP, P_PWSUITE, P_AKMSUITE: begin
            if (pos < 2'd3) begin
               byte_buf = {byte_buf[15:0], b};
               field_pos = pos + 2'd1;
            end else if (phase == P_GROUP) begin
               emit_suite(KIND_GROUP, 2'd0, byte_buf, b, 1'b0);
               enter(P_PWCNT);
            end else begin
               kind = (phase == P_PWSUITE) ? KIND_PAIRWISE : KIND_AKM;
               emit_suite(kind, taken[1:0], byte_buf, b, 1'b0);
               taken++;
               field_pos = 2'd0;
               if (taken >= capped(announced)) begin
                  close_list(kind == KIND_PAIRWISE);
               end
            end
         end
         P_PWSKIP, P_AKMSKIP: begin
            if (skip_left != 0) begin
               skip_left--;
            end
            if (skip_left == 0) begin
               if (phase == P_PWSKIP) begin
                  enter(P_AKMCNT);
               end else begin
                  after_akm_list();
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic end_element();
      status_type  st;
      logic [23:0] doui;
      logic [7:0]  dtype;
      st = fault;
      doui = wpa_format ? OUI_VENDOR : OUI_IEEE;
      dtype = wpa_format ? CIPHER_TKIP : CIPHER_CCMP;
      case (phase)
         P_START, P_HDR, P_VER, P_PWSUITE, P_AKMSUITE: begin
            st = ST_SHORT;
         end
         P_GROUP: begin
            emit_suite(KIND_GROUP, 2'd0, doui, dtype, 1'b1);
            st = ST_OK;
         end
         P_PWCNT: begin
            emit_suite(KIND_PAIRWISE, 2'd0, doui, dtype, 1'b1);
            pw_seen = 3'd1;
            st = ST_OK;
         end
         default: ;
      endcase
      emit_other(KIND_END, 16'd0, st, pw_seen, akm_seen, 1'b1);
      clear_parse();
   endtask

   always @(posedge clock) begin
      rec_type got;
      rec_type want;
      if (reset) begin
         wpa_format = 1'b0;
         clear_parse();
         expected_records.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.record_kind = kind_type'(rsp.record_kind);
            got.suite_index = rsp.suite_index;
            got.suite_oui = rsp.suite_oui;
            got.suite_type = rsp.suite_type;
            got.oui_class = rsp.oui_class;
            got.suite_known = rsp.suite_known;
            got.from_default = rsp.from_default;
            got.capabilities_value = rsp.capabilities_value;
            got.status = status_type'(rsp.status);
            got.pairwise_total = rsp.pairwise_total;
            got.akm_total = rsp.akm_total;
            got.last_record = rsp.last_record;
            if (expected_records.size() == 0) begin
               note_failure("record with no expectation waiting", '0, got);
            end else begin
               want = expected_records.pop_front();
               if (got !== want) begin
                  note_failure("record mismatch", want, got);
               end
            end
         end
         if (csr_we) begin
            wpa_format = csr_wdata;
         end
         if (req.valid && req.ready) begin
            if (req.byte_present) begin
               parse_body_byte(req.byte_value);
            end
            if (req.end_of_body) begin
               end_element();
            end
         end
      end
      pending_records <= expected_records.size();
   end

endmodule

/* verif/tb_wlan_security_ie_parser_top.sv */
// Testbench top for the security information element parser: drives element bodies
// (directed corner cases, then random elements under changing idle patterns) and the format register.
// Depends on wsie_pkg, wsie_if.sv, the parser RTL and wsie_record_checker.
`timescale 1ns / 1ps

module tb_wlan_security_ie_parser_top;
   import wsie_pkg::*;

   localparam int HOLD_CYCLES = 400;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_we;
   logic       csr_wdata;
   int         fail_count;
   int         pending_records;
   int         send_idle_pct;
   int         recv_idle_pct;
   logic       hold_req;
   logic       format_now;
   logic [7:0] body[$];
   int         items_sent;

   wsie_req_if req_chan();
   wsie_rsp_if rsp_chan();

   wlan_security_ie_parser_top #(.MAX_SUITES(4)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   wsie_record_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req             (req_chan),
      .rsp             (rsp_chan),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_records (pending_records)
   );

   always #2 clock = ~clock;

   initial begin
      #1_000_000;
      $display("tb_wlan_security_ie_parser_top: done, errors");
      $finish;
   end

   // The receiver holds off for a long stretch once the stimulus asks for it.
   initial begin
      int hold_cycles;
      rsp_chan.ready = 1'b0;
      hold_cycles = 0;
      forever begin
         @(posedge clock);
         if (hold_req && hold_cycles < HOLD_CYCLES) begin
            rsp_chan.ready <= 1'b0;
            hold_cycles++;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_item(input logic [7:0] b, input logic present, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.byte_value <= b;
      req_chan.byte_present <= present;
      req_chan.end_of_body <= last;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   // Sends the first keep bytes of the body (all when keep is negative), with an
   // occasional empty transaction, and closes the element when asked to.
   task automatic send_element(input int keep, input bit close);
      int n;
      bit end_on_byte;
      n = (keep < 0 || keep > body.size()) ? body.size() : keep;
      end_on_byte = close && (n > 0) && ($urandom_range(1) == 1);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(19) == 0) begin
            send_item(8'($urandom_range(255)), 1'b0, 1'b0);
         end
         send_item(body[i], 1'b1, end_on_byte && (i == n - 1));
      end
      if (close && !end_on_byte) begin
         send_item(8'($urandom_range(255)), 1'b0, 1'b1);
      end
      body.delete();
   endtask

   task automatic set_format(input logic v);
      req_chan.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_records != 0);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      format_now = v;
   endtask

   task automatic put_word(input logic [15:0] w);
      body.push_back(w[7:0]);
      body.push_back(w[15:8]);
   endtask

   task automatic put_suite(input logic [23:0] oui, input logic [7:0] stype);
      body.push_back(oui[23:16]);
      body.push_back(oui[15:8]);
      body.push_back(oui[7:0]);
      body.push_back(stype);
   endtask

   task automatic put_random_suite();
      int          r;
      logic [23:0] oui;
      logic [7:0]  stype;
      r = $urandom_range(99);
      oui = (r < 45) ? OUI_IEEE : (r < 80) ? OUI_VENDOR : 24'($urandom);
      stype = ($urandom_range(3) != 0) ? 8'($urandom_range(20)) : 8'($urandom);
      put_suite(oui, stype);
   endtask

   task automatic put_header(input bit intact);
      logic [7:0] hdr[4];
      int         k;
      hdr[0] = OUI_VENDOR[23:16];
      hdr[1] = OUI_VENDOR[15:8];
      hdr[2] = OUI_VENDOR[7:0];
      hdr[3] = WPA_OUI_TYPE;
      if (!intact) begin
         k = $urandom_range(3);
         hdr[k] = hdr[k] ^ 8'($urandom_range(255, 1));
      end
      foreach (hdr[i]) begin
         body.push_back(hdr[i]);
      end
   endtask

   // Long lists carry up to three surplus suites; with a count above seven the body then ends while skipping.
   task automatic put_list(input logic [15:0] count);
      put_word(count);
      for (int i = 0; i < count && i < 7; i++) begin
         put_random_suite();
      end
   endtask

   function automatic logic [15:0] random_count();
      int r;
      r = $urandom_range(99);
      if (r < 70) begin
         return 16'($urandom_range(4));
      end
      if (r < 90) begin
         return 16'($urandom_range(7, 5));
      end
      return 16'($urandom);
   endfunction

   task automatic build_random_element();
      if (format_now) begin
         put_header($urandom_range(9) != 0);
      end
      put_word(($urandom_range(9) != 0) ? VERSION_ONE : 16'($urandom));
      put_random_suite();
      put_list(random_count());
      put_list(random_count());
      if (!format_now) begin
         put_word(16'($urandom));
      end
      if ($urandom_range(6) == 0) begin
         repeat ($urandom_range(5, 1)) body.push_back(8'($urandom));
      end
   endtask

   task automatic run_random(input int item_goal);
      int keep;
      while (items_sent < item_goal) begin
         if ($urandom_range(9) < 3) begin
            set_format(1'($urandom_range(1)));
         end
         if ($urandom_range(99) < 80) begin
            build_random_element();
         end else begin
            repeat ($urandom_range(10)) body.push_back(8'($urandom));
         end
         keep = ($urandom_range(3) == 0) ? $urandom_range(body.size()) : -1;
         send_element(keep, 1'b1);
      end
   endtask

   task automatic put_full_rsn();
      put_word(VERSION_ONE);
      put_random_suite();
      put_list(16'd4);
      put_list(16'd4);
      put_word(16'($urandom));
   endtask

   initial begin
      int waited;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      hold_req = 1'b0;
      items_sent = 0;
      send_idle_pct = 33;
      recv_idle_pct = 60;
      req_chan.valid = 1'b0;
      req_chan.byte_value = 8'd0;
      req_chan.byte_present = 1'b0;
      req_chan.end_of_body = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      set_format(1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_element(-1, 1'b1);
      body.push_back(8'h01);
      send_element(-1, 1'b1);
      put_word(16'h0002);
      put_suite(OUI_IEEE, CIPHER_CCMP);
      send_element(-1, 1'b1);
      put_word(VERSION_ONE);
      send_element(-1, 1'b1);
      put_word(VERSION_ONE);
      put_suite(OUI_IEEE, CIPHER_CCMP);
      send_element(5, 1'b1);
      put_word(VERSION_ONE);
      put_suite(OUI_IEEE, CIPHER_CCMP);
      body.push_back(8'h01);
      send_element(-1, 1'b1);
      put_word(VERSION_ONE);
      put_suite(OUI_IEEE, 8'd0);
      put_word(16'd3);
      put_suite(OUI_IEEE, 8'd13);
      put_suite(OUI_IEEE, 8'd14);
      send_element(-1, 1'b1);
      put_word(VERSION_ONE);
      put_suite(OUI_IEEE, 8'hFF);
      put_word(16'd2);
      put_suite(OUI_IEEE, 8'd13);
      put_suite(OUI_IEEE, 8'd14);
      put_word(16'd3);
      put_suite(OUI_IEEE, 8'd0);
      put_suite(OUI_IEEE, 8'd18);
      put_suite(OUI_IEEE, 8'd19);
      put_word(16'hFFFF);
      body.push_back(8'h5A);
      send_element(-1, 1'b1);
      put_word(VERSION_ONE);
      put_suite(OUI_VENDOR, 8'd5);
      put_list(16'd6);
      put_list(16'd5);
      body.push_back(8'h80);
      send_element(-1, 1'b1);
      put_word(VERSION_ONE);
      put_suite(24'hFFFFFF, 8'd0);
      put_word(16'd0);
      put_word(16'd0);
      put_word(16'h00AA);
      send_element(-1, 1'b1);
      put_word(VERSION_ONE);
      put_random_suite();
      put_word(16'd1);
      put_suite(OUI_VENDOR, 8'd6);
      body.push_back(8'h02);
      send_element(-1, 1'b1);
      put_word(VERSION_ONE);
      put_random_suite();
      put_word(16'd0);
      put_word(16'd2);
      put_suite(OUI_VENDOR, 8'd1);
      body.push_back(8'h00);
      send_element(-1, 1'b1);
      put_word(VERSION_ONE);
      put_random_suite();
      put_list(16'hFFFF);
      send_element(-1, 1'b1);
      put_word(VERSION_ONE);
      put_random_suite();
      put_word(16'd0);
      put_list(16'd6);
      send_element(-1, 1'b1);

      set_format(1'b1);
      put_header(1'b1);
      put_word(VERSION_ONE);
      put_suite(OUI_VENDOR, CIPHER_TKIP);
      put_word(16'd2);
      put_suite(OUI_VENDOR, 8'd5);
      put_suite(OUI_VENDOR, 8'd6);
      put_word(16'd2);
      put_suite(OUI_VENDOR, 8'd2);
      put_suite(OUI_VENDOR, 8'd3);
      send_element(-1, 1'b1);
      put_header(1'b0);
      put_word(VERSION_ONE);
      put_random_suite();
      send_element(-1, 1'b1);
      put_header(1'b0);
      body.push_back(8'h01);
      send_element(-1, 1'b1);
      put_header(1'b1);
      put_word(VERSION_ONE);
      put_random_suite();
      put_list(16'd5);
      put_list(16'd6);
      send_element(-1, 1'b1);
      put_header(1'b1);
      put_word(VERSION_ONE);
      body.push_back(8'h00);
      send_element(-1, 1'b1);
      put_header(1'b1);
      put_word(VERSION_ONE);
      put_suite(OUI_VENDOR, 8'd4);
      send_element(-1, 1'b1);
      put_header(1'b1);
      put_word(16'h0100);
      send_element(-1, 1'b1);

      // Format changes in the middle of an element.
      put_header(1'b1);
      put_word(VERSION_ONE);
      send_element(-1, 1'b0);
      set_format(1'b0);
      send_element(-1, 1'b1);
      put_word(VERSION_ONE);
      put_random_suite();
      put_word(16'd0);
      put_word(16'd1);
      send_element(-1, 1'b0);
      set_format(1'b1);
      put_random_suite();
      put_word(16'h1234);
      send_element(-1, 1'b1);

      run_random(items_sent + 30);
      send_idle_pct = 60;
      recv_idle_pct = 33;
      run_random(items_sent + 40);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_format(1'b0);
      hold_req = 1'b1;
      put_full_rsn();
      send_element(-1, 1'b1);
      put_full_rsn();
      send_element(-1, 1'b1);
      run_random(items_sent + 20);

      req_chan.valid <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending_records != 0 && waited < 20000);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_records == 0) begin
         $display("tb_wlan_security_ie_parser_top: done, clean");
      end else begin
         $display("tb_wlan_security_ie_parser_top: done, errors");
      end
      $finish;
   end

endmodule
